FILE: rtl/getu_pkg.sv
// Shared types, constants and helpers for the gradient edge threshold unit.
// Used by every module under rtl/; depends on nothing.
package getu_pkg;

  // Frame geometry limits
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 2;
  localparam int T_W       = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd2;

  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH    = 11'd640;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT   = 11'd480;
  localparam logic [T_W-1:0]   RST_EDGE_THRESHOLD = 8'd8;

  // Pixel data
  localparam int CH_W  = 8;
  localparam int SUM_W = 10;

  // Position and lag counters
  localparam int WD_W   = $clog2(MAX_WIDTH + 1);
  localparam int HT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LEAD_W = 11;
  localparam int CMP_W0 = (LEAD_W > WD_W) ? LEAD_W : WD_W;
  localparam int CMP_W  = ((CMP_W0 > HT_W) ? CMP_W0 : HT_W) + 1;

  // Descriptor queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Sum line memory: holds two rows plus one, with slack for queued descriptors
  localparam int LINE_DEPTH = 2 * MAX_WIDTH + 1;
  localparam int MEM_AW     = $clog2(LINE_DEPTH + 2 * QDEPTH + 8);
  localparam int MEM_DEPTH  = 1 << MEM_AW;

  // Magnitude compare datapath
  localparam int NCNT_W = 2;                   // neighbour count 1..3
  localparam int K_W    = 5;                   // 3*nv*nh, at most 27
  localparam int AVN_W  = SUM_W + NCNT_W;
  localparam int SQ_W   = 2 * AVN_W;
  localparam int LHS_W  = SQ_W + 1;
  localparam int TN_W   = T_W + K_W;
  localparam int RHS_W  = 2 * TN_W;
  localparam int FIN_W  = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  typedef struct packed {
    logic [WD_W-1:0] width;
    logic [HT_W-1:0] height;
    logic [T_W-1:0]  thresh;
  } cfg_t;

  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [SUM_W-1:0]  data;
  } line_wr_t;

  // One pending result: where its pixel sits in the line and which neighbours count
  typedef struct packed {
    logic [MEM_AW-1:0] base;
    logic              above_en;
    logic              below_in;
    logic              below_en;
    logic              left_en;
    logic              right_in;
    logic              right_en;
    logic              last;
  } desc_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_VRD,
    BK_HRD,
    BK_MUL1,
    BK_MUL2,
    BK_CMP
  } back_state_t;

  function automatic logic [WD_W-1:0] eff_width(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return WD_W'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      return WD_W'(MAX_WIDTH);
    end
    return WD_W'(v);
  endfunction

  function automatic logic [HT_W-1:0] eff_height(input logic [CFG_W-1:0] v);
    if (v == '0) begin
      return HT_W'(1);
    end else if (int'(v) > MAX_HEIGHT) begin
      return HT_W'(MAX_HEIGHT);
    end
    return HT_W'(v);
  endfunction

endpackage

FILE: rtl/getu_line.sv
// Sum line memory: one write port, two registered read ports.
// Depends on getu_pkg.
module getu_line
  import getu_pkg::*;
(
  input  logic              clk,
  input  line_wr_t          wr,
  input  logic [MEM_AW-1:0] rd_addr_a,
  input  logic [MEM_AW-1:0] rd_addr_b,
  output logic [SUM_W-1:0]  rd_data_a,
  output logic [SUM_W-1:0]  rd_data_b
);

  logic [SUM_W-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

FILE: rtl/getu_front.sv
// Front end: takes pixel and flush beats, writes channel sums, tracks the lag and
// output position, and issues one descriptor per result. Depends on getu_pkg.
module getu_front
  import getu_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  logic            in_action,
  input  logic [CH_W-1:0] in_red,
  input  logic [CH_W-1:0] in_green,
  input  logic [CH_W-1:0] in_blue,
  input  cfg_t            cfg,
  output line_wr_t        line_wr,
  output logic            q_push,
  output desc_t           q_desc
);

  logic [MEM_AW-1:0] wr_ptr_r, wr_ptr_nxt, wr_cur;
  logic [LEAD_W-1:0] lead_r, lead_nxt, lead_inc, lead_cur;
  logic [COL_W-1:0]  out_col_r, out_col_nxt;
  logic [ROW_W-1:0]  out_row_r, out_row_nxt;
  logic              is_pix;
  logic [CMP_W-1:0]  w_c, h_c, lead_c;
  logic              below_in, right_in;

  always_comb begin
    is_pix   = ~in_action;
    lead_inc = (lead_r == {LEAD_W{1'b1}}) ? lead_r : lead_r + LEAD_W'(1);
    lead_cur = is_pix ? lead_inc : lead_r;
    wr_cur   = is_pix ? wr_ptr_r + MEM_AW'(1) : wr_ptr_r;
    w_c      = CMP_W'(cfg.width);
    h_c      = CMP_W'(cfg.height);
    lead_c   = CMP_W'(lead_cur);
    below_in = (CMP_W'(out_row_r) + CMP_W'(1)) < h_c;
    right_in = (CMP_W'(out_col_r) + CMP_W'(1)) < w_c;

    q_push = accept && (is_pix ? (lead_c > w_c) : (lead_r != '0));

    q_desc.base     = wr_cur - MEM_AW'(lead_cur);
    q_desc.above_en = (out_row_r != '0);
    q_desc.below_in = below_in;
    q_desc.below_en = below_in && ((w_c + CMP_W'(1)) <= lead_c);
    q_desc.left_en  = (out_col_r != '0);
    q_desc.right_in = right_in;
    q_desc.right_en = right_in && (lead_cur >= LEAD_W'(2));
    q_desc.last     = !below_in && !right_in;

    line_wr.en   = accept && is_pix;
    line_wr.addr = wr_ptr_r;
    line_wr.data = SUM_W'(in_red) + SUM_W'(in_green) + SUM_W'(in_blue);

    wr_ptr_nxt  = accept ? wr_cur : wr_ptr_r;
    lead_nxt    = lead_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (accept) begin
      lead_nxt = q_push ? lead_cur - LEAD_W'(1) : lead_cur;
    end
    if (q_push) begin
      if (right_in) begin
        out_col_nxt = out_col_r + COL_W'(1);
      end else begin
        out_col_nxt = '0;
        out_row_nxt = below_in ? out_row_r + ROW_W'(1) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      lead_r    <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      lead_r    <= lead_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  // pending count never runs past one row plus the pixel just taken
  a_lead_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(lead_r) <= MAX_WIDTH + 1)
    else $error("front: lag count out of range");

  // a pixel arriving with a full row pending must release a result
  a_pix_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_action && (CMP_W'(lead_r) >= CMP_W'(cfg.width))) |-> q_push)
    else $error("front: pixel with full lag produced no descriptor");

endmodule

FILE: rtl/getu_queue.sv
// Short descriptor queue between front and back ends, in flip-flops.
// Depends on getu_pkg.
module getu_queue
  import getu_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t head,
  output logic  full,
  output logic  empty
);

  desc_t              slot [QDEPTH];
  logic [QAW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == QCNT_W'(QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QAW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QAW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full))
    else $error("queue: push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && empty))
    else $error("queue: pop while empty");

endmodule

FILE: rtl/getu_back.sv
// Back end: fetches the four neighbour sums for a descriptor, runs the exact
// magnitude compare and holds the result beat. Depends on getu_pkg.
module getu_back
  import getu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  input  desc_t             q_head,
  input  logic              q_empty,
  output logic              q_pop,
  output logic [MEM_AW-1:0] rd_addr_a,
  output logic [MEM_AW-1:0] rd_addr_b,
  input  logic [SUM_W-1:0]  rd_data_a,
  input  logic [SUM_W-1:0]  rd_data_b,
  input  logic              out_pop,
  output logic              out_empty,
  output logic              out_edge_res,
  output logic              out_frame_last
);

  back_state_t state_r, state_nxt;
  desc_t       desc_r;

  logic [SUM_W-1:0]  av_r, lo_v, hi_v, lo_h, hi_h, av_nxt, ah;
  logic [AVN_W-1:0]  avn_r, ahn_r;
  logic [TN_W-1:0]   tn_r;
  logic [SQ_W-1:0]   sqv_r, sqh_r;
  logic [RHS_W-1:0]  rsq_r;
  logic [NCNT_W-1:0] nv, nh;
  logic [K_W-1:0]    knn;
  logic [FIN_W-1:0]  lhs, rhs;
  logic [MEM_AW-1:0] w_a;
  logic              out_valid_r, out_edge_r, out_last_r, out_load;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) state_nxt = BK_VRD;
      end
      BK_VRD:  state_nxt = BK_HRD;
      BK_HRD:  state_nxt = BK_MUL1;
      BK_MUL1: state_nxt = BK_MUL2;
      BK_MUL2: state_nxt = BK_CMP;
      BK_CMP: begin
        if (out_load) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    w_a      = MEM_AW'(cfg.width);
    q_pop    = (state_r == BK_IDLE) && !q_empty;
    out_load = (state_r == BK_CMP) && (!out_valid_r || out_pop);
    if (state_r == BK_VRD) begin
      rd_addr_a = desc_r.base - w_a;
      rd_addr_b = desc_r.base + w_a;
    end else begin
      rd_addr_a = desc_r.base - MEM_AW'(1);
      rd_addr_b = desc_r.base + MEM_AW'(1);
    end
  end

  // datapath arithmetic; a missing neighbour reads as zero
  always_comb begin
    lo_v   = desc_r.above_en ? rd_data_a : '0;
    hi_v   = desc_r.below_en ? rd_data_b : '0;
    lo_h   = desc_r.left_en  ? rd_data_a : '0;
    hi_h   = desc_r.right_en ? rd_data_b : '0;
    av_nxt = (hi_v >= lo_v) ? hi_v - lo_v : lo_v - hi_v;
    ah     = (hi_h >= lo_h) ? hi_h - lo_h : lo_h - hi_h;
    nv     = NCNT_W'(1) + NCNT_W'(desc_r.above_en) + NCNT_W'(desc_r.below_in);
    nh     = NCNT_W'(1) + NCNT_W'(desc_r.left_en) + NCNT_W'(desc_r.right_in);
    knn    = K_W'(nv) * K_W'(nh) * K_W'(3);
    lhs    = FIN_W'(sqv_r) + FIN_W'(sqh_r);
    rhs    = FIN_W'(rsq_r);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_head;
    end
    if (state_r == BK_HRD) begin
      av_r <= av_nxt;
    end
    if (state_r == BK_MUL1) begin
      avn_r <= AVN_W'(av_r) * AVN_W'(nh);
      ahn_r <= AVN_W'(ah) * AVN_W'(nv);
      tn_r  <= TN_W'(cfg.thresh) * TN_W'(knn);
    end
    if (state_r == BK_MUL2) begin
      sqv_r <= SQ_W'(avn_r) * SQ_W'(avn_r);
      sqh_r <= SQ_W'(ahn_r) * SQ_W'(ahn_r);
      rsq_r <= RHS_W'(tn_r) * RHS_W'(tn_r);
    end
    if (out_load) begin
      out_edge_r <= (lhs > rhs);
      out_last_r <= desc_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_edge_res   = out_edge_r;
  assign out_frame_last = out_last_r;

  // a fresh result only ever comes out of the compare step
  a_load_from_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == BK_CMP))
    else $error("back: result beat appeared outside compare step");

  // once busy, the sequencer only returns to idle right after the compare
  a_busy_until_cmp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != BK_IDLE) |=> (state_r != BK_IDLE) || $past(state_r == BK_CMP))
    else $error("back: sequence abandoned early");

endmodule

FILE: rtl/gradient_edge_threshold_unit.sv
// Gradient edge threshold unit: raster RGB pixels in, one edge flag per pixel out,
// each flag released image_width beats after its pixel; flush beats drain the tail.
// The front end takes one input beat per clock while its 4-entry descriptor queue
// has room and writes channel sums into a two-port line memory (no clearing pass
// after reset). The back end takes each result through its steps in order (taking a
// descriptor, two neighbour fetches on the memory's two read ports, two multiply
// stages, one compare that waits while the previous result is unread) and takes no
// new descriptor until the compare is done, so the queue fills under a steady stream.
// Configuration writes take effect at once and belong in idle periods only.
module gradient_edge_threshold_unit
  import getu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic                 in_action,
  input  logic [CH_W-1:0]      in_red,
  input  logic [CH_W-1:0]      in_green,
  input  logic [CH_W-1:0]      in_blue,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic                 out_edge_res,
  output logic                 out_frame_last,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]  img_width_r, img_height_r;
  logic [T_W-1:0]    edge_thresh_r;
  cfg_t              cfg;
  logic              accept;
  line_wr_t          line_wr;
  logic              q_push, q_pop, q_full, q_empty;
  desc_t             q_desc, q_head;
  logic [MEM_AW-1:0] rd_addr_a, rd_addr_b;
  logic [SUM_W-1:0]  rd_data_a, rd_data_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r   <= RST_IMAGE_WIDTH;
      img_height_r  <= RST_IMAGE_HEIGHT;
      edge_thresh_r <= RST_EDGE_THRESHOLD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:    img_width_r   <= cfg_data;
        REG_IMAGE_HEIGHT:   img_height_r  <= cfg_data;
        REG_EDGE_THRESHOLD: edge_thresh_r <= cfg_data[T_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width  = eff_width(img_width_r);
    cfg.height = eff_height(img_height_r);
    cfg.thresh = edge_thresh_r;
  end

  assign in_full = q_full;
  assign accept  = in_push && !q_full;

  getu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_action (in_action),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .cfg       (cfg),
    .line_wr   (line_wr),
    .q_push    (q_push),
    .q_desc    (q_desc)
  );

  getu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_desc),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  getu_line u_line (
    .clk       (clk),
    .wr        (line_wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  getu_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .q_head         (q_head),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .rd_addr_a      (rd_addr_a),
    .rd_addr_b      (rd_addr_b),
    .rd_data_a      (rd_data_a),
    .rd_data_b      (rd_data_b),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_edge_res   (out_edge_res),
    .out_frame_last (out_frame_last)
  );

endmodule
